### rtl/core/lpht_pkg.sv
`timescale 1ns / 1ps

package lpht_pkg;

  // Table geometry. The slot index is the low bits of the hashed key.
  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);

  // Fixed field widths of the item and result beats.
  localparam int KEY_W     = 24;
  localparam int STATUS_W  = 2;
  localparam int SLOT_O_W  = 8;
  localparam int ENTRIES_W = 8;

  // Multiplicative hash constant.
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  // Operation codes.
  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_CMP,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the incoming beat
    logic hash;     // compute the home slot
    logic read;     // read the slot under the probe pointer
    logic advance;  // step the probe pointer with wraparound
    logic finish;   // decide, commit an insert and present the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic used;   // probed slot is occupied
    logic match;  // probed slot holds the key
    logic last;   // every slot has been visited
  } dp_sts_t;

endpackage

### rtl/core/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Flow: take start, hash the home slot, read and compare each probed slot, then finish.
// A new start is taken in the strobe cycle; no new item is taken while one is in flight.
// Each probe is a registered key store read, then the compare.
// Reset clears the occupancy bits and the entry count at once; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module linear_probe_hash_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation_i,
  input  logic [lpht_pkg::KEY_W-1:0]         key_i,
  output logic                               result_valid_o,
  output logic [lpht_pkg::STATUS_W-1:0]      status_o,
  output logic [lpht_pkg::SLOT_O_W-1:0]      slot_o,
  output logic [lpht_pkg::ENTRIES_W-1:0]     entries_o
);
  import lpht_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Probe sequencer.
  lpht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Table storage, hashing and result registers.
  lpht_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .entries_o      (entries_o)
  );

endmodule

### rtl/core/lpht_ctrl.sv
`timescale 1ns / 1ps

module lpht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lpht_pkg::dp_sts_t   sts_i,
  output lpht_pkg::ctrl_cmd_t cmd_o
);
  import lpht_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state. A probe ends on an empty slot, on the key, or after a full lap.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_HASH;
        end
      end
      S_HASH:   state_d = S_READ;
      S_READ:   state_d = S_CMP;
      S_CMP: begin
        if (!sts_i.used || sts_i.match || sts_i.last) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_READ;
        end
      end
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs. On a full lap the pointer still steps, so it ends at the home slot.
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_HASH:   cmd_o.hash = 1'b1;
      S_READ:   cmd_o.read = 1'b1;
      S_CMP:    cmd_o.advance = sts_i.used && !sts_i.match;
      S_FINISH: cmd_o.finish = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule

### rtl/core/lpht_dp.sv
`timescale 1ns / 1ps

module lpht_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lpht_pkg::ctrl_cmd_t                 cmd_i,
  output lpht_pkg::dp_sts_t                   sts_o,
  input  logic                                operation_i,
  input  logic [lpht_pkg::KEY_W-1:0]          key_i,
  output logic                                result_valid_o,
  output logic [lpht_pkg::STATUS_W-1:0]       status_o,
  output logic [lpht_pkg::SLOT_O_W-1:0]       slot_o,
  output logic [lpht_pkg::ENTRIES_W-1:0]      entries_o
);
  import lpht_pkg::*;

  logic [KEY_W-1:0]  mem_q [TABLE_SLOTS];
  logic              used_q [TABLE_SLOTS];
  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [SLOT_W-1:0] idx_q;
  logic [SLOT_W-1:0] cnt_q;
  logic [SLOT_W-1:0] count_q;
  logic [KEY_W-1:0]  rd_key_q;
  logic              rd_used_q;
  logic [SLOT_W-1:0] home;
  logic              hit;
  logic              do_insert;
  status_e           status_d;
  status_e           status_q;
  logic [SLOT_W-1:0] count_d;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] entries_q;
  logic              valid_q;

  // Home slot: only the low slot bits of key and multiplier reach the low product bits.
  assign home = key_q[SLOT_W-1:0] * HASH_MULT[SLOT_W-1:0];

  // Beat capture, hashing and probe stepping.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      key_q <= key_i;
    end
    if (cmd_i.hash) begin
      idx_q <= home;
      cnt_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= (idx_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx_q + 1'b1;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Key store with registered read; written only by a committed insert.
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_key_q <= mem_q[idx_q];
    end
    if (cmd_i.finish && do_insert) begin
      mem_q[idx_q] <= key_q;
    end
  end

  // Occupancy bits and their registered read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        used_q[i] <= 1'b0;
      end
      rd_used_q <= 1'b0;
    end else begin
      if (cmd_i.read) begin
        rd_used_q <= used_q[idx_q];
      end
      if (cmd_i.finish && do_insert) begin
        used_q[idx_q] <= 1'b1;
      end
    end
  end

  assign sts_o.used  = rd_used_q;
  assign sts_o.match = rd_key_q == key_q;
  assign sts_o.last  = cnt_q == SLOT_W'(TABLE_SLOTS - 1);

  // Outcome of the probe. One slot always stays empty, so a probe ends.
  assign hit = rd_used_q && (rd_key_q == key_q);

  always_comb begin
    do_insert = 1'b0;
    count_d   = count_q;
    if (hit) begin
      status_d = ST_FOUND;
    end else if (op_q == OP_FIND) begin
      status_d = ST_ABSENT;
    end else if (count_q == SLOT_W'(TABLE_SLOTS - 1) || rd_used_q) begin
      status_d = ST_FULL;
    end else begin
      status_d  = ST_INSERTED;
      do_insert = 1'b1;
      count_d   = count_q + 1'b1;
    end
  end

  // Occupied count and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
      if (cmd_i.finish) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload, held until the next result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q  <= status_d;
      slot_q    <= idx_q;
      entries_q <= count_d;
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign slot_o         = SLOT_O_W'(slot_q);
  assign entries_o      = ENTRIES_W'(entries_q);

endmodule
